@@ rtl/pci_bar_sizing_filter_defines.svh @@
// ----------------------------------------------------------------------------
// pci bar sizing filter: assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef PCI_BAR_SIZING_FILTER_DEFINES_SVH
`define PCI_BAR_SIZING_FILTER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define PBSF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// a stalled beat keeps its payload until taken
`define PBSF_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) \
        (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

@@ rtl/pbsf_pkg.sv @@
// ----------------------------------------------------------------------------
// pbsf_pkg
// types, offsets and codes shared by the bar sizing filter modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbsf_pkg;

    localparam int DEF_NUM_DEVICES = 32;
    localparam int DEV_IDX_W       = 5;
    localparam int DEV_SLOTS       = 2 ** DEV_IDX_W;
    localparam int NUM_FLAGS       = 7;

    localparam logic [7:0] OFF_BAR_FIRST = 8'h10;
    localparam logic [7:0] OFF_BAR_LAST  = 8'h24;
    localparam logic [7:0] OFF_ROM       = 8'h30;
    localparam logic [7:0] OFF_IRQ_LINE  = 8'h3c;
    localparam logic [2:0] ROM_BIT       = 3'd6;
    localparam logic [2:0] LEN_DWORD     = 3'd4;

    localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;
    localparam logic [31:0] ROM_SIZING    = 32'hffff_fffe;
    localparam logic [31:0] IO_SIZING     = 32'h0000_ffff;

    localparam logic       REQ_READ  = 1'b0;
    localparam logic       REQ_WRITE = 1'b1;

    localparam logic [1:0] LEVEL_NONE  = 2'd0;
    localparam logic [1:0] LEVEL_WRITE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_REFUSED   = 2'd1;
    localparam logic [1:0] STATUS_NO_ACCESS = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [4:0]  device_index;
        logic [7:0]  reg_offset;
        logic [2:0]  access_len;
        logic [31:0] write_value;
        logic [31:0] current_value;
        logic [31:0] region_size;
        logic        region_is_mem;
        logic        region_is_io;
        logic [7:0]  device_irq;
        logic [1:0]  access_level;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
        logic        forward_write;
    } rsp_t;

    typedef struct packed {
        logic                 en;
        logic [NUM_FLAGS-1:0] value;
    } flag_wr_t;

endpackage

`default_nettype wire

@@ rtl/pci_bar_sizing_filter.sv @@
// ----------------------------------------------------------------------------
// pci_bar_sizing_filter
// guest config access filter with emulated bar and rom sizing
// ----------------------------------------------------------------------------
// Each accepted config access gives exactly one reply beat, passing through the
// input register and then the result register; a new access can be taken in
// every cycle while the result side is not stalled. The rate is set by the sizing
// flag table: the flags of the addressed device are read, updated and written
// back in the single stage between the input register and the result register,
// so each access sees the flags left by the one before it. The table is cleared
// by reset itself, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module pci_bar_sizing_filter #(
    parameter int NUM_DEVICES = pbsf_pkg::DEF_NUM_DEVICES
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pbsf_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output pbsf_pkg::rsp_t m_data
);
    import pbsf_pkg::*;

    // only slots reachable through device_index need storage
    localparam int FLAG_DEPTH = (NUM_DEVICES < DEV_SLOTS) ? NUM_DEVICES : DEV_SLOTS;
    localparam int IDX_W      = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    req_t                 in_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    rsp_t                 out_data_reg;
    logic                 advance;
    logic [NUM_FLAGS-1:0] rd_flags;
    rsp_t                 rsp;
    flag_wr_t             flag_wr;
    flag_wr_t             flag_wr_gated;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign in_valid_next  = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    assign flag_wr_gated.en    = flag_wr.en && advance;
    assign flag_wr_gated.value = flag_wr.value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= rsp;
        end
    end

    pbsf_flags #(
        .FLAG_DEPTH (FLAG_DEPTH),
        .IDX_W      (IDX_W)
    ) u_flags (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .idx      (in_data_reg.device_index[IDX_W-1:0]),
        .rd_flags (rd_flags),
        .wr       (flag_wr_gated)
    );

    pbsf_access #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_access (
        .req     (in_data_reg),
        .flags   (rd_flags),
        .rsp     (rsp),
        .flag_wr (flag_wr)
    );

endmodule

`default_nettype wire

@@ rtl/pbsf_flags.sv @@
// ----------------------------------------------------------------------------
// pbsf_flags
// per-device sizing flag table, one read and one write port, cleared by reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbsf_flags #(
    parameter int FLAG_DEPTH = pbsf_pkg::DEF_NUM_DEVICES,
    parameter int IDX_W      = pbsf_pkg::DEV_IDX_W
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [IDX_W-1:0]               idx,
    output logic [pbsf_pkg::NUM_FLAGS-1:0] rd_flags,
    input  pbsf_pkg::flag_wr_t             wr
);
    import pbsf_pkg::*;

    logic [NUM_FLAGS-1:0] flags_reg [FLAG_DEPTH];

    assign rd_flags = flags_reg[idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FLAG_DEPTH; i++) begin
                flags_reg[i] <= '0;
            end
        end else if (wr.en) begin
            flags_reg[idx] <= wr.value;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pbsf_access.sv @@
// ----------------------------------------------------------------------------
// pbsf_access
// decodes one config access, builds the reply and the sizing flag update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbsf_access #(
    parameter int NUM_DEVICES = pbsf_pkg::DEF_NUM_DEVICES
) (
    input  pbsf_pkg::req_t                 req,
    input  logic [pbsf_pkg::NUM_FLAGS-1:0] flags,
    output pbsf_pkg::rsp_t                 rsp,
    output pbsf_pkg::flag_wr_t             flag_wr
);
    import pbsf_pkg::*;

    logic                 no_access;
    logic                 is_write;
    logic                 is_bar;
    logic                 is_rom;
    logic [7:0]           off_rel;
    logic [2:0]           bit_sel;
    logic [NUM_FLAGS-1:0] mask;
    logic                 sizing;
    logic [31:0]          size_mask;

    assign is_write  = (req.req_type == REQ_WRITE);
    assign no_access = (req.access_level == LEVEL_NONE) ||
                       (32'(req.device_index) >= NUM_DEVICES);
    assign is_bar    = (req.reg_offset >= OFF_BAR_FIRST) && (req.reg_offset <= OFF_BAR_LAST) &&
                       (req.reg_offset[1:0] == 2'b00);
    assign is_rom    = (req.reg_offset == OFF_ROM);
    assign off_rel   = req.reg_offset - OFF_BAR_FIRST;
    assign bit_sel   = is_rom ? ROM_BIT : off_rel[4:2];
    assign mask      = NUM_FLAGS'(1) << bit_sel;

    assign sizing = is_rom ? (req.write_value == ALL_ONES || req.write_value == ROM_SIZING)
                           : (req.write_value == ALL_ONES ||
                              (req.region_is_io && req.write_value == IO_SIZING));

    // synthesized size mask, memory wins over io
    always_comb begin
        if (is_rom) begin
            size_mask = {~req.region_size[31:11], 10'b0, req.current_value[0]};
        end else if (req.region_is_mem) begin
            size_mask = {~req.region_size[31:4], req.current_value[3:0]};
        end else if (req.region_is_io) begin
            size_mask = {16'b0, ~req.region_size[15:2], 2'b01};
        end else begin
            size_mask = req.current_value;
        end
    end

    always_comb begin
        rsp.read_data     = '0;
        rsp.status        = STATUS_OK;
        rsp.forward_write = 1'b0;
        flag_wr.en        = 1'b0;
        flag_wr.value     = sizing ? (flags | mask) : (flags & ~mask);

        if (no_access) begin
            rsp.read_data = is_write ? '0 : ALL_ONES;
            rsp.status    = STATUS_NO_ACCESS;
        end else if (is_bar || is_rom) begin
            if (req.access_len != LEN_DWORD) begin
                rsp.status = STATUS_REFUSED;
            end else if (is_write) begin
                flag_wr.en = 1'b1;
                if (!sizing && req.write_value != req.current_value &&
                    !(is_rom && req.write_value == '0)) begin
                    rsp.status = STATUS_REFUSED;
                end
            end else begin
                rsp.read_data = ((flags & mask) != '0) ? size_mask : req.current_value;
            end
        end else if (!is_write) begin
            rsp.read_data = (req.reg_offset == OFF_IRQ_LINE) ? 32'(req.device_irq)
                                                              : req.current_value;
        end else if (req.access_level == LEVEL_WRITE) begin
            rsp.forward_write = 1'b1;
        end else begin
            rsp.status = STATUS_REFUSED;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pbsf_checker.sv @@
// ----------------------------------------------------------------------------
// pbsf_checker
// port-level checks on the reply channel of the bar sizing filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pci_bar_sizing_filter_defines.svh"

module pbsf_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input pbsf_pkg::rsp_t m_data
);
    import pbsf_pkg::*;

    `PBSF_ASSERT_HOLD(a_rsp_hold, aclk, aresetn, m_valid, m_ready, m_data, "reply beat changed while stalled")

    // forwarded writes are always accepted ones
    `PBSF_ASSERT(a_fwd_ok, aclk, aresetn, (m_valid && m_data.forward_write) |-> (m_data.status == STATUS_OK), "forwarded write with bad status")

    // no-access replies carry either zero or all ones
    `PBSF_ASSERT(a_noacc_data, aclk, aresetn, (m_valid && m_data.status == STATUS_NO_ACCESS) |-> (m_data.read_data == '0 || m_data.read_data == ALL_ONES), "no-access reply with odd data")

    // a full input side with an idle output cannot stall
    `PBSF_ASSERT(a_no_stall, aclk, aresetn, (!m_valid && !s_ready) |=> m_valid, "input stalled with free output")

endmodule

bind pci_bar_sizing_filter pbsf_checker u_pbsf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
